// File: hdl/slm_pkg.sv
// Package for the stereo RMS level meter.
// Widths, reset values, register indexes and the lane status/command types.
// No dependencies.
package slm_pkg;

    localparam int SUM_W         = 44;
    localparam int LEVEL_W       = 16;
    localparam int COEF_W        = 16;
    localparam int FLOOR_W       = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int EXP_W         = 6;
    localparam int FRAC_W        = 16;
    localparam int LG_W          = EXP_W + FRAC_W;
    localparam int MANT_W        = 31;
    localparam int DB_W          = 18;
    localparam int ATT_W         = 24;
    localparam int FL_W          = FLOOR_W + FRAC_W;

    localparam int DEF_MAX_BLOCK_FRAMES = 4096;
    localparam int DEF_SAMPLE_BITS      = 16;

    localparam logic [DB_W-1:0]    DB_PER_LOG2_Q16 = 18'd197283;
    localparam logic [COEF_W-1:0]  COEF_RESET      = 16'd39322;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET     = 7'd60;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_COEF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_DB       = 2'd1;

    typedef struct packed {
        logic accept;
        logic last;
        logic take;
    } t_lane_cmd;

    typedef struct packed {
        logic               idle;
        logic               done;
        logic [LEVEL_W-1:0] level;
    } t_lane_stat;

endpackage

// File: hdl/slm_in_if.sv
// Input channel of the level meter: one stereo frame per request.
// Depends on nothing.
interface slm_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last_frame;

    modport source (output valid, left_sample, right_sample, last_frame, input ready);
    modport sink   (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

// File: hdl/slm_out_if.sv
// Output channel of the level meter: both smoothed levels per request.
// Depends on nothing.
interface slm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] level_left;
    logic [15:0] level_right;

    modport source (output valid, level_left, level_right, input ready);
    modport sink   (input valid, level_left, level_right, output ready);
endinterface

// File: hdl/slm_div.sv
// Shift-subtract unsigned divider, one quotient bit per cycle.
// Standalone; used by each lane for the mean and the level.
module slm_div #(
    parameter int NW = 44,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [NW-1:0] r_quo;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        diff  = trial - {1'b0, r_div};
        ge    = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: hdl/slm_lane.sv
// One channel lane: square and accumulate, then mean, log2, dB map and smoothing.
// Depends on slm_pkg and slm_div.
module slm_lane import slm_pkg::*; #(
    parameter int MAX_BLOCK_FRAMES = DEF_MAX_BLOCK_FRAMES,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_cmd                     i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [COEF_W-1:0]             i_coef,
    input  logic [FLOOR_W-1:0]            i_floor,
    output t_lane_stat                    o_stat
);
    localparam int FW  = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam int DVW = (FW > FLOOR_W) ? FW : FLOOR_W;
    localparam int SQW = 2 * SAMPLE_BITS;
    localparam int AW  = ((SQW > SUM_W) ? SQW : SUM_W) + 1;
    localparam logic [LG_W-1:0] FULL = LG_W'((2 * (SAMPLE_BITS - 1)) * 65536);
    localparam logic [AW-1:0]   SUM_MAX = AW'({SUM_W{1'b1}});

    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_DSTART, S_DIV, S_NORM, S_SQM, S_SQN,
        S_ATTM, S_ATTC, S_LDIV, S_SMM, S_SMA, S_DONE
    } t_state;

    t_state                r_state;
    logic [SQW-1:0]        r_sq;
    logic                  r_last;
    logic [SUM_W-1:0]      r_sum;
    logic [FW-1:0]         r_frames;
    logic [SUM_W-1:0]      r_norm;
    logic [EXP_W-1:0]      r_exp;
    logic [MANT_W-1:0]     r_m;
    logic [2*MANT_W-1:0]   r_prod;
    logic [FRAC_W-1:0]     r_frac;
    logic [3:0]            r_it;
    logic [ATT_W-1:0]      r_att;
    logic [LEVEL_W-1:0]    r_level;
    logic [2*LEVEL_W-1:0]  r_p0;
    logic [2*LEVEL_W:0]    r_p1;
    logic [LEVEL_W-1:0]    r_smooth;

    logic [SAMPLE_BITS-1:0] mag;
    logic [AW-1:0]          acc;
    logic [SUM_W-1:0]       sum_sat;
    logic [FW-1:0]          frames_nx;
    logic [FLOOR_W-1:0]     fd;
    logic [FL_W-1:0]        fl;
    logic [LG_W-1:0]        lg;
    logic [LG_W+DB_W:0]     att_sum;
    logic [MANT_W:0]        sq_top;
    logic [2*LEVEL_W+1:0]   sm_sum;
    logic                   div_start;
    logic [SUM_W-1:0]       div_dividend;
    logic [DVW-1:0]         div_divisor;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quo;

    always_comb begin
        mag       = i_sample[SAMPLE_BITS-1] ? (~i_sample + SAMPLE_BITS'(1)) : i_sample;
        acc       = AW'(r_sum) + AW'(r_sq);
        sum_sat   = (acc > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : acc[SUM_W-1:0];
        frames_nx = (r_frames < FW'(MAX_BLOCK_FRAMES)) ? r_frames + FW'(1) : r_frames;
        fd        = (i_floor == '0) ? FLOOR_W'(1) : i_floor;
        fl        = {fd, {FRAC_W{1'b0}}};
        lg        = {r_exp, r_frac};
        att_sum   = (LG_W+DB_W+1)'((FULL - lg) * DB_PER_LOG2_Q16) + (LG_W+DB_W+1)'(32768);
        sq_top    = r_prod[2*MANT_W-1:MANT_W-1];
        sm_sum    = (2*LEVEL_W+2)'(r_p0) + (2*LEVEL_W+2)'(r_p1) + (2*LEVEL_W+2)'(32768);
        div_start = (r_state == S_DSTART) ||
                    ((r_state == S_ATTC) && (r_att < ATT_W'(fl)));
        if (r_state == S_DSTART) begin
            div_dividend = r_sum;
            div_divisor  = DVW'(r_frames);
        end else begin
            div_dividend = SUM_W'(fl - r_att[FL_W-1:0]);
            div_divisor  = DVW'(fd);
        end
    end

    slm_div #(.NW(SUM_W), .DW(DVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sum    <= '0;
            r_frames <= '0;
            r_smooth <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.accept) begin
                        r_sq    <= mag * mag;
                        r_last  <= i_cmd.last;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum    <= sum_sat;
                    r_frames <= frames_nx;
                    r_state  <= r_last ? S_DSTART : S_IDLE;
                end
                S_DSTART: begin
                    r_sum    <= '0;
                    r_frames <= '0;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (div_quo == '0) begin
                            r_level <= '0;
                            r_state <= S_SMM;
                        end else begin
                            r_norm  <= div_quo;
                            r_exp   <= EXP_W'(SUM_W - 1);
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (r_norm[SUM_W-1]) begin
                        r_m     <= r_norm[SUM_W-1 -: MANT_W];
                        r_it    <= '0;
                        r_state <= S_SQM;
                    end else begin
                        r_norm <= {r_norm[SUM_W-2:0], 1'b0};
                        r_exp  <= r_exp - EXP_W'(1);
                    end
                end
                S_SQM: begin
                    r_prod  <= r_m * r_m;
                    r_state <= S_SQN;
                end
                S_SQN: begin
                    r_m     <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
                    r_frac  <= {r_frac[FRAC_W-2:0], sq_top[MANT_W]};
                    r_it    <= r_it + 4'd1;
                    r_state <= (r_it == 4'd15) ? S_ATTM : S_SQM;
                end
                S_ATTM: begin
                    if (lg >= FULL) begin
                        r_level <= LEVEL_MAX;
                        r_state <= S_SMM;
                    end else begin
                        r_att   <= att_sum[LG_W+DB_W-1:FRAC_W];
                        r_state <= S_ATTC;
                    end
                end
                S_ATTC: begin
                    if (r_att >= ATT_W'(fl)) begin
                        r_level <= '0;
                        r_state <= S_SMM;
                    end else begin
                        r_state <= S_LDIV;
                    end
                end
                S_LDIV: begin
                    if (div_done) begin
                        r_level <= (|div_quo[SUM_W-1:LEVEL_W]) ? LEVEL_MAX
                                                               : div_quo[LEVEL_W-1:0];
                        r_state <= S_SMM;
                    end
                end
                S_SMM: begin
                    r_p0    <= i_coef * r_smooth;
                    r_p1    <= (((LEVEL_W+1)'(1) << LEVEL_W) - (LEVEL_W+1)'(i_coef))
                               * r_level;
                    r_state <= S_SMA;
                end
                S_SMA: begin
                    r_smooth <= sm_sum[2*LEVEL_W-1:LEVEL_W];
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (i_cmd.take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.idle  = (r_state == S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_stat.level = r_smooth;
endmodule

// File: hdl/slm_merge.sv
// Merge stage: joins both lane results into the output register.
// Depends on slm_pkg and slm_out_if.
module slm_merge import slm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_lane_stat i_left,
    input  t_lane_stat i_right,
    output logic       o_take,
    slm_out_if.source  o_out
);
    logic               r_valid;
    logic [LEVEL_W-1:0] r_left;
    logic [LEVEL_W-1:0] r_right;
    logic               take;

    assign take = i_left.done && i_right.done && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_left  <= i_left.level;
            r_right <= i_right.level;
        end
    end

    assign o_take            = take;
    assign o_out.valid       = r_valid;
    assign o_out.level_left  = r_left;
    assign o_out.level_right = r_right;
endmodule

// File: hdl/stereo_rms_level_meter_top.sv
// Stereo RMS level meter, top level: config registers, two lanes, merge stage.
// Depends on slm_pkg, slm_in_if, slm_out_if, slm_lane, slm_merge.
//
// Each input request is one stereo frame; last_frame closes a measurement
// block. Frames that do not close a block produce nothing; each is squared,
// then added to the sum with saturation. A closing frame yields one output
// request with both smoothed levels: each lane runs a 44-step serial divide
// for the mean, a normalize shift, sixteen squaring steps for the log2
// fraction and, unless the level clips or falls below the floor, a second
// 44-step divide for the level. A silent block skips all but the first divide.
// Input ready is high only while both lanes are idle.
// The output register lets new frames enter while a result waits; a lane that
// finishes while the receiver stalls holds until the register frees up.
// Reset clears sums, frame count, smoothed levels and loads the default
// coefficient and floor. Config writes: index 0 smoothing_coef, index 1
// floor_db; other indexes are ignored.
module stereo_rms_level_meter_top import slm_pkg::*; #(
    parameter int MAX_BLOCK_FRAMES = DEF_MAX_BLOCK_FRAMES,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    slm_in_if.sink                i_in,
    slm_out_if.source             o_out
);
    logic [COEF_W-1:0]  r_coef;
    logic [FLOOR_W-1:0] r_floor;
    t_lane_cmd          cmd_l;
    t_lane_cmd          cmd_r;
    t_lane_stat         stat_l;
    t_lane_stat         stat_r;
    logic               take;
    logic               accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= COEF_RESET;
            r_floor <= FLOOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SMOOTHING_COEF: r_coef  <= i_cfg_data[COEF_W-1:0];
                CFG_FLOOR_DB:       r_floor <= i_cfg_data[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = stat_l.idle && stat_r.idle;
    assign accept     = i_in.valid && i_in.ready;

    assign cmd_l = '{accept: accept, last: i_in.last_frame, take: take};
    assign cmd_r = '{accept: accept, last: i_in.last_frame, take: take};

    slm_lane #(.MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd_l),
        .i_sample (i_in.left_sample),
        .i_coef   (r_coef),
        .i_floor  (r_floor),
        .o_stat   (stat_l)
    );

    slm_lane #(.MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd_r),
        .i_sample (i_in.right_sample),
        .i_coef   (r_coef),
        .i_floor  (r_floor),
        .o_stat   (stat_r)
    );

    slm_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_left  (stat_l),
        .i_right (stat_r),
        .o_take  (take),
        .o_out   (o_out)
    );
endmodule
